FILE: hw/rtl/dtns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtns_pkg: shared types and constants
// Register map, reset values, sine polynomial coefficients and state types.
// ----------------------------------------------------------------------------
package dtns_pkg;

	localparam int CFG_W    = 16;
	localparam int INDEX_W  = 3;
	localparam int TIME_W   = 32;
	localparam int RAND_W   = 16;
	localparam int SAMPLE_W = 24;
	localparam int ACC_W    = 32;

	// Register indexes on the configuration channel
	typedef enum logic [INDEX_W-1:0] {
		REG_ALPHA_AMP   = 3'd0,
		REG_ALPHA_FREQ  = 3'd1,
		REG_BETA_AMP    = 3'd2,
		REG_BETA_FREQ   = 3'd3,
		REG_NOISE_SCALE = 3'd4,
		REG_NOISE_PERS  = 3'd5
	} reg_index_t;

	// Reset values
	localparam logic [CFG_W-1:0] RST_ALPHA_AMP   = 16'd5120;
	localparam logic [CFG_W-1:0] RST_ALPHA_FREQ  = 16'd2560;
	localparam logic [CFG_W-1:0] RST_BETA_AMP    = 16'd2560;
	localparam logic [CFG_W-1:0] RST_BETA_FREQ   = 16'd5120;
	localparam logic [CFG_W-1:0] RST_NOISE_SCALE = 16'd1280;
	localparam logic [CFG_W-1:0] RST_NOISE_PERS  = 16'd58982;

	// sin(pi/2*x) ~ x*(C1 - x^2*(C3 - x^2*C5)), Q16
	localparam logic [16:0] SIN_C1 = 17'd102944;
	localparam logic [16:0] SIN_C3 = 17'd42178;
	localparam logic [16:0] SIN_C5 = 17'd4770;
	localparam logic [16:0] SIN_ONE = 17'h10000;

	typedef struct packed {
		logic [CFG_W-1:0] alpha_amplitude;
		logic [CFG_W-1:0] alpha_frequency;
		logic [CFG_W-1:0] beta_amplitude;
		logic [CFG_W-1:0] beta_frequency;
		logic [CFG_W-1:0] noise_scale;
		logic [CFG_W-1:0] noise_persistence;
	} cfg_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_WHITE,
		F_LEAK,
		F_PHASE_A,
		F_PHASE_B
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SQUARE,
		B_POLY5,
		B_POLY3,
		B_POLY1,
		B_SCALE,
		B_OUT
	} back_state_t;

endpackage

FILE: hw/rtl/dtns_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtns_fifo: small register queue
// Holds up to DEPTH entries; write when not full, read when not empty.
// ----------------------------------------------------------------------------
module dtns_fifo #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: hw/rtl/dtns_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtns_front: request intake, noise update and phase lookup
// Updates the leaky noise accumulator and turns the sample time into two
// sine table indexes, using one 32x16 multiplier.
// ----------------------------------------------------------------------------
module dtns_front import dtns_pkg::*; #(
	parameter int NOISE_BITS      = 16,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cfg_t                               cfg,
	input  logic                               push,
	output logic                               full,
	input  logic [TIME_W-1:0]                  sample_time,
	input  logic [RAND_W-1:0]                  random_word,
	output logic                               q_push,
	input  logic                               q_full,
	output logic [2*SINE_TABLE_BITS+ACC_W-1:0] q_data
);

	localparam int STB = SINE_TABLE_BITS;
	localparam int WMW = 49 - NOISE_BITS;
	localparam int AW  = ((WMW > ACC_W) ? WMW : ACC_W) + 2;
	localparam logic [32:0] HALF = 33'(1) << (NOISE_BITS - 1);
	localparam logic signed [AW-1:0] ACC_HI = AW'(64'sd2147483647);
	localparam logic signed [AW-1:0] ACC_LO = AW'(-64'sd2147483648);

	front_state_t state_q, state_d;

	logic [23:0]           t_q;
	logic [31:0]           dmag_q;
	logic                  dneg_q;
	logic [WMW-1:0]        white_q;
	logic [31:0]           leak_q;
	logic                  lneg_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [STB-1:0]        idx_a_q;

	logic signed [32:0]    d33;
	logic [31:0]           dmag;
	logic [31:0]           acc_u, amag;
	logic [31:0]           mul_a;
	logic [15:0]           mul_b;
	logic [47:0]           prod;
	logic [48:0]           wsum, lsum;
	logic signed [AW-1:0]  leak_s, white_s, acc_sum;
	logic signed [ACC_W-1:0] acc_new;

	// Noise offset around half range
	assign d33  = $signed({17'b0, random_word}) - $signed(HALF);
	assign dmag = d33[32] ? 32'(-d33) : d33[31:0];

	assign acc_u = acc_q;
	assign amag  = acc_u[31] ? (32'd0 - acc_u) : acc_u;

	assign prod = 48'(mul_a) * 48'(mul_b);
	assign wsum = {1'b0, prod} + {16'b0, HALF};
	assign lsum = {1'b0, prod} + 49'd32768;

	assign leak_s  = $signed(AW'(leak_q));
	assign white_s = $signed(AW'(white_q));
	assign acc_sum = (lneg_q ? -leak_s : leak_s) + (dneg_q ? -white_s : white_s);
	assign acc_new = (acc_sum > ACC_HI) ? ACC_W'(ACC_HI) :
	                 (acc_sum < ACC_LO) ? ACC_W'(ACC_LO) : ACC_W'(acc_sum);

	assign q_data = {idx_a_q, prod[23 -: STB], acc_q};

	always_comb begin
		state_d = state_q;
		full    = 1'b1;
		q_push  = 1'b0;
		mul_a   = {8'b0, t_q};
		mul_b   = cfg.alpha_frequency;
		unique case (state_q)
			F_IDLE: begin
				full = 1'b0;
				if (push) begin
					state_d = F_WHITE;
				end
			end
			F_WHITE: begin
				mul_a   = dmag_q;
				mul_b   = cfg.noise_scale;
				state_d = F_LEAK;
			end
			F_LEAK: begin
				mul_a   = amag;
				mul_b   = cfg.noise_persistence;
				state_d = F_PHASE_A;
			end
			F_PHASE_A: begin
				state_d = F_PHASE_B;
			end
			F_PHASE_B: begin
				mul_b  = cfg.beta_frequency;
				q_push = !q_full;
				if (!q_full) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			acc_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_PHASE_A) begin
				acc_q <= acc_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			t_q    <= sample_time[23:0];
			dmag_q <= dmag;
			dneg_q <= d33[32];
		end
		if (state_q == F_WHITE) begin
			white_q <= wsum[NOISE_BITS +: WMW];
		end
		if (state_q == F_LEAK) begin
			leak_q <= lsum[47:16];
			lneg_q <= acc_q[ACC_W-1];
		end
		if (state_q == F_PHASE_A) begin
			idx_a_q <= prod[23 -: STB];
		end
	end

endmodule

FILE: hw/rtl/dtns_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtns_back: sine evaluation and output mix
// Evaluates both tones with one shared 17x17 multiplier, adds the noise
// accumulator and saturates to the 24-bit sample.
// ----------------------------------------------------------------------------
module dtns_back import dtns_pkg::*; #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cfg_t                               cfg,
	input  logic                               q_empty,
	output logic                               q_pop,
	input  logic [2*SINE_TABLE_BITS+ACC_W-1:0] q_data,
	input  logic                               o_full,
	output logic                               o_push,
	output logic [SAMPLE_W-1:0]                o_data
);

	localparam int STB = SINE_TABLE_BITS;
	localparam int QB  = STB - 2;
	localparam int EW  = 2 * STB + ACC_W;
	localparam logic signed [33:0] OUT_HI = 34'sd8388607;
	localparam logic signed [33:0] OUT_LO = -34'sd8388608;

	back_state_t state_q, state_d;

	logic [STB-1:0]          idx_b_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [16:0]             x_q, x2_q, t_q, mag_q;
	logic                    neg_q, tone_q;
	logic signed [18:0]      sum_q;

	logic [STB-1:0]          load_idx;
	logic [16:0]             xr, x_load;
	logic [16:0]             mul_a, mul_b;
	logic [33:0]             prod, vsum;
	logic [16:0]             y;
	logic signed [18:0]      tone_s;
	logic signed [33:0]      total;

	// Quarter-wave folding: odd quadrants mirror, upper half negates
	assign load_idx = (state_q == B_IDLE) ? q_data[EW-1 -: STB] : idx_b_q;
	assign xr       = 17'(load_idx[QB-1:0]) << (16 - QB);
	assign x_load   = load_idx[STB-2] ? (SIN_ONE - xr) : xr;

	assign prod   = 34'(mul_a) * 34'(mul_b);
	assign y      = prod[32:16];
	assign vsum   = prod + 34'd32768;
	assign tone_s = $signed({3'b0, vsum[31:16]});

	assign total  = 34'(acc_q) + 34'(sum_q);
	assign o_data = (total > OUT_HI) ? SAMPLE_W'(OUT_HI) :
	                (total < OUT_LO) ? SAMPLE_W'(OUT_LO) : SAMPLE_W'(total);

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		o_push  = 1'b0;
		mul_a   = x_q;
		mul_b   = x_q;
		unique case (state_q)
			B_IDLE: begin
				q_pop = !q_empty;
				if (!q_empty) begin
					state_d = B_SQUARE;
				end
			end
			B_SQUARE: begin
				state_d = B_POLY5;
			end
			B_POLY5: begin
				mul_a   = x2_q;
				mul_b   = SIN_C5;
				state_d = B_POLY3;
			end
			B_POLY3: begin
				mul_a   = x2_q;
				mul_b   = t_q;
				state_d = B_POLY1;
			end
			B_POLY1: begin
				mul_b   = t_q;
				state_d = B_SCALE;
			end
			B_SCALE: begin
				mul_a   = {1'b0, tone_q ? cfg.beta_amplitude : cfg.alpha_amplitude};
				mul_b   = mag_q;
				state_d = tone_q ? B_OUT : B_SQUARE;
			end
			B_OUT: begin
				o_push = !o_full;
				if (!o_full) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					idx_b_q <= q_data[ACC_W+STB-1 -: STB];
					acc_q   <= q_data[ACC_W-1:0];
					x_q     <= x_load;
					neg_q   <= load_idx[STB-1];
					sum_q   <= '0;
					tone_q  <= 1'b0;
				end
			end
			B_SQUARE: x2_q <= prod[32:16];
			B_POLY5:  t_q  <= SIN_C3 - prod[32:16];
			B_POLY3:  t_q  <= SIN_C1 - prod[32:16];
			B_POLY1:  mag_q <= (y > SIN_ONE) ? SIN_ONE : y;
			B_SCALE: begin
				sum_q  <= sum_q + (neg_q ? -tone_s : tone_s);
				tone_q <= 1'b1;
				x_q    <= x_load;
				neg_q  <= load_idx[STB-1];
			end
			B_OUT: begin
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/dual_tone_noise_signal_synth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_tone_noise_signal_synth: two sine tones plus leaky noise
// Sums alpha and beta tones with a leaky white-noise accumulator per sample.
// ----------------------------------------------------------------------------
// Usage:
//  - Input queue side: drive sample_time (Q16.16 s) and random_word, raise
//    push; the request is taken on a clock edge where full is low.
//  - Output queue side: while empty is low, sample_value (Q15.8 uV, saturated)
//    holds the oldest sample; pop on an edge with empty low takes it.
//  - Config: cfg_valid/cfg_index/cfg_data write one 16-bit register; cfg_ready
//    is always high. Indexes above 5 are dropped. Write only while idle.
// Datapath:
//  - The front end uses one 32x16 multiplier for four products: white noise,
//    leak, two phases. It takes no new request until it is back in idle.
//  - The back end computes ten products on one shared 17x17 multiplier for
//    the two sine polynomials, plus load and write-out; it pops no new
//    request until the write-out is done, so it sets the sustained throughput.
//  - A request passes front end, middle queue, back end and output queue.
// Reset and stalls:
//  - arst_n clears the noise accumulator, loads the register defaults and
//    empties both queues. A stalled consumer fills the two-entry output queue,
//    then the two-entry middle queue, then holds the front end busy, full high.
// ----------------------------------------------------------------------------
module dual_tone_noise_signal_synth import dtns_pkg::*; #(
	parameter int NOISE_BITS      = 16,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input request queue
	input  logic                       push,
	output logic                       full,
	input  logic [TIME_W-1:0]          sample_time,
	input  logic [RAND_W-1:0]          random_word,
	// result queue
	output logic                       empty,
	input  logic                       pop,
	output logic signed [SAMPLE_W-1:0] sample_value,
	// configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [INDEX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);

	localparam int EW = 2 * SINE_TABLE_BITS + ACC_W;

	cfg_t cfg_q;

	// front -> back queue
	logic          mq_push, mq_full, mq_pop, mq_empty;
	logic [EW-1:0] mq_wr_data, mq_rd_data;

	// back -> output queue
	logic                o_push, o_full;
	logic [SAMPLE_W-1:0] o_data, o_rd_data;

	assign cfg_ready    = 1'b1;
	assign sample_value = $signed(o_rd_data);

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_amplitude   <= RST_ALPHA_AMP;
			cfg_q.alpha_frequency   <= RST_ALPHA_FREQ;
			cfg_q.beta_amplitude    <= RST_BETA_AMP;
			cfg_q.beta_frequency    <= RST_BETA_FREQ;
			cfg_q.noise_scale       <= RST_NOISE_SCALE;
			cfg_q.noise_persistence <= RST_NOISE_PERS;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_ALPHA_AMP:   cfg_q.alpha_amplitude   <= cfg_data;
				REG_ALPHA_FREQ:  cfg_q.alpha_frequency   <= cfg_data;
				REG_BETA_AMP:    cfg_q.beta_amplitude    <= cfg_data;
				REG_BETA_FREQ:   cfg_q.beta_frequency    <= cfg_data;
				REG_NOISE_SCALE: cfg_q.noise_scale       <= cfg_data;
				REG_NOISE_PERS:  cfg_q.noise_persistence <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front end: noise state update and phase indexes
	dtns_front #(
		.NOISE_BITS      (NOISE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.full        (full),
		.sample_time (sample_time),
		.random_word (random_word),
		.q_push      (mq_push),
		.q_full      (mq_full),
		.q_data      (mq_wr_data)
	);

	// Decoupling queue between the two halves
	dtns_fifo #(
		.WIDTH (EW),
		.DEPTH (2)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mq_push),
		.wr_data (mq_wr_data),
		.full    (mq_full),
		.rd_en   (mq_pop),
		.rd_data (mq_rd_data),
		.empty   (mq_empty)
	);

	// Back end: sine polynomials and final mix
	dtns_back #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (mq_empty),
		.q_pop   (mq_pop),
		.q_data  (mq_rd_data),
		.o_full  (o_full),
		.o_push  (o_push),
		.o_data  (o_data)
	);

	// Result queue: keeps the back end running while the consumer stalls
	dtns_fifo #(
		.WIDTH (SAMPLE_W),
		.DEPTH (2)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (o_push),
		.wr_data (o_data),
		.full    (o_full),
		.rd_en   (pop),
		.rd_data (o_rd_data),
		.empty   (empty)
	);

endmodule
